// File: hw/rtl/lmvs_pkg.sv
// Package for the low-memory victim selector: sizes, codes, payload and
// control types shared by the selector modules. Depends on nothing.
`default_nettype none

package lmvs_pkg;

    // Sizing
    localparam int TABLE_ENTRIES    = 4;
    localparam int VICTIM_SLOTS     = 4;
    localparam int TICKS_PER_SECOND = 100;

    localparam int CFG_PAIRS   = 4;
    localparam int CFG_PAIR_W  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int PAIRS_USED  = (TABLE_ENTRIES < CFG_PAIRS) ? TABLE_ENTRIES : CFG_PAIRS;
    localparam int PAIR_W      = (PAIRS_USED > 1) ? $clog2(PAIRS_USED) : 1;
    localparam int CNT_W       = $clog2(VICTIM_SLOTS + 1);
    localparam int SLOT_W      = (VICTIM_SLOTS > 1) ? $clog2(VICTIM_SLOTS) : 1;
    localparam int STEP_W      = (CNT_W > PAIR_W) ? CNT_W : PAIR_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LEVEL_0    = 3'd4;

    // Reset values of the threshold table
    localparam logic [30:0] THR_RESET_0 = 31'(3 * 512);
    localparam logic [30:0] THR_RESET_1 = 31'(2 * 1024);
    localparam logic [30:0] THR_RESET_2 = 31'(4 * 1024);
    localparam logic [30:0] THR_RESET_3 = 31'(16 * 1024);
    localparam logic signed [10:0] LVL_RESET_0 = 11'sd0;
    localparam logic signed [10:0] LVL_RESET_1 = 11'sd1;
    localparam logic signed [10:0] LVL_RESET_2 = 11'sd6;
    localparam logic signed [10:0] LVL_RESET_3 = 11'sd12;

    // Score level meaning no match (score maximum plus one)
    localparam logic signed [10:0] LEVEL_NONE = 11'sd1001;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_TASK  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_IDLE   = 2'd0,
        RES_VICTIM = 2'd1,
        RES_DONE   = 2'd2,
        RES_ABORT  = 2'd3
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LEVEL,
        ST_SEARCH,
        ST_INSERT,
        ST_EMIT,
        ST_DONE,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        OP_THR,
        OP_KEY_GT,
        OP_SUB_SAT,
        OP_TIME,
        OP_ADD
    } alu_op_t;

    typedef struct packed {
        logic [21:0]        id;
        logic signed [10:0] score;
        logic [30:0]        size;
    } slot_t;

    typedef struct packed {
        logic             clear;
        logic             insert;
        logic [CNT_W-1:0] pos;
        slot_t            entry;
    } slot_cmd_t;

    typedef struct packed {
        alu_op_t            op;
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] c;
        logic signed [32:0] d;
    } alu_req_t;

    typedef struct packed {
        logic        flag;
        logic [31:0] value;
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/lmvs_in_if.sv
// Input channel of the victim selector: valid/ready and the item fields.
// Stands alone; no package needed.
`default_nettype none

interface lmvs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] free_pages;
    logic signed [31:0] file_pages;
    logic [30:0]        lru_pages;
    logic               scan_requested;
    logic [21:0]        task_id;
    logic signed [10:0] task_score;
    logic [30:0]        task_size;
    logic               is_kernel_thread;
    logic               has_memory;
    logic               is_dying;
    logic [31:0]        now_ticks;

    modport source (
        output valid, kind, free_pages, file_pages, lru_pages, scan_requested,
               task_id, task_score, task_size, is_kernel_thread, has_memory,
               is_dying, now_ticks,
        input  ready
    );

    modport sink (
        input  valid, kind, free_pages, file_pages, lru_pages, scan_requested,
               task_id, task_score, task_size, is_kernel_thread, has_memory,
               is_dying, now_ticks,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/lmvs_out_if.sv
// Result channel of the victim selector: valid/ready and the result fields.
// Stands alone; no package needed.
`default_nettype none

interface lmvs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [10:0] chosen_level;
    logic [21:0]        victim_id;
    logic signed [10:0] victim_score;
    logic [30:0]        victim_size;
    logic signed [31:0] reclaimable;
    logic               last;

    modport source (
        output valid, result_kind, chosen_level, victim_id, victim_score,
               victim_size, reclaimable, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, chosen_level, victim_id, victim_score,
               victim_size, reclaimable, last,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/lmvs_alu.sv
// Shared compare/arithmetic unit of the victim selector: threshold test,
// rank key compare, saturating subtract, wrapping time test and add.
// Depends on lmvs_pkg.
`default_nettype none

module lmvs_alu (
    input  lmvs_pkg::alu_req_t req,
    output lmvs_pkg::alu_rsp_t rsp
);
    logic signed [33:0] rhs;
    logic signed [33:0] diff;
    logic signed [33:0] sum;
    logic [31:0]        wrap_diff;

    // One subtractor (saturating subtract, time test) and one adder (add)
    assign rhs       = (req.op == lmvs_pkg::OP_SUB_SAT) ? 34'(req.d) : 34'(req.c);
    assign diff      = 34'(req.a) - rhs;
    assign sum       = 34'(req.a) + 34'(req.c);
    assign wrap_diff = diff[31:0];

    always_comb
    begin
        rsp = '0;
        case (req.op)
            lmvs_pkg::OP_THR:
            begin
                rsp.flag = (req.a < req.c) && (req.b < req.d);
            end
            lmvs_pkg::OP_KEY_GT:
            begin
                rsp.flag = (req.a > req.c) || ((req.a == req.c) && (req.b > req.d));
            end
            lmvs_pkg::OP_SUB_SAT:
            begin
                // clamp at the most negative 32-bit value
                if (diff < -34'sd2147483648)
                begin
                    rsp.value = 32'h8000_0000;
                end
                else
                begin
                    rsp.value = diff[31:0];
                end
            end
            lmvs_pkg::OP_TIME:
            begin
                // at or before in wrapping time
                rsp.value = wrap_diff;
                rsp.flag  = (wrap_diff == 32'd0) || wrap_diff[31];
            end
            lmvs_pkg::OP_ADD:
            begin
                rsp.value = sum[31:0];
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end
endmodule

`default_nettype wire

// File: hw/rtl/lmvs_slots.sv
// Victim slot store: entries kept ascending by (score, size), insert with
// shift, fill count and one indexed read port. Depends on lmvs_pkg.
`default_nettype none

module lmvs_slots (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmvs_pkg::slot_cmd_t           cmd,
    input  logic [lmvs_pkg::SLOT_W-1:0]   rd_idx,
    output lmvs_pkg::slot_t               rd_data,
    output logic [lmvs_pkg::CNT_W-1:0]    count
);
    localparam int NS = lmvs_pkg::VICTIM_SLOTS;
    localparam int CW = lmvs_pkg::CNT_W;

    lmvs_pkg::slot_t slot_reg  [NS];
    lmvs_pkg::slot_t slot_next [NS];
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            full;

    assign full  = (count_reg == CW'(NS));
    assign count = count_reg;

    // Work out each entry's next value from its fixed neighbours
    for (genvar i = 0; i < NS; i++)
    begin : g_entry
        lmvs_pkg::slot_t up;
        lmvs_pkg::slot_t down;

        if (i < NS - 1)
        begin : g_up
            assign up = slot_reg[i + 1];
        end
        else
        begin : g_up_last
            assign up = slot_reg[i];
        end

        if (i > 0)
        begin : g_down
            assign down = slot_reg[i - 1];
        end
        else
        begin : g_down_first
            assign down = slot_reg[i];
        end

        always_comb
        begin
            slot_next[i] = slot_reg[i];
            if (cmd.insert)
            begin
                if (full)
                begin
                    // drop the smallest, shift the lower part down
                    if (CW'(i + 1) < cmd.pos)
                    begin
                        slot_next[i] = up;
                    end
                    else if (CW'(i + 1) == cmd.pos)
                    begin
                        slot_next[i] = cmd.entry;
                    end
                end
                else
                begin
                    // open a hole at pos, shift the upper part up
                    if ((CW'(i) > cmd.pos) && (CW'(i) <= count_reg))
                    begin
                        slot_next[i] = down;
                    end
                    else if (CW'(i) == cmd.pos)
                    begin
                        slot_next[i] = cmd.entry;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    // Track the fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.insert && !full)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Indexed read
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < NS; i++)
        begin
            if (rd_idx == lmvs_pkg::SLOT_W'(i))
            begin
                rd_data = slot_reg[i];
            end
        end
    end
endmodule

`default_nettype wire

// File: hw/rtl/low_memory_victim_selector.sv
// Top level of the low-memory victim selector: sequencer, threshold table,
// scan state and result register. Depends on lmvs_pkg, lmvs_in_if,
// lmvs_out_if, lmvs_alu and lmvs_slots.
//
//  channel   dir  handshake          carries
//  item      in   valid/ready        begin, task and end items
//  result    out  valid/ready        idle, victim, done, aborted results
//  cfg       in   cfg_we (no wait)   threshold and score level registers
//
// Begin: the threshold pairs (up to 4) are tested one at a time, and an idle
// result is handed over when no scan opens. Task: a skipped task goes back to
// idle, one that aborts the scan hands over an aborted result; a ranked task is
// compared with each kept slot it passes (the shared compare unit looks at one
// slot a cycle). End: one result a cycle while the result side takes them.
// Reset clears the scan state and loads the threshold defaults. A stalled
// result side holds the sequencer only when it has a result to hand over.
`default_nettype none

module low_memory_victim_selector (
    input  logic                                clk,
    input  logic                                rst_n,
    lmvs_in_if.sink                             item,
    lmvs_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [lmvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int CW = lmvs_pkg::CNT_W;
    localparam int SW = lmvs_pkg::STEP_W;

    // Sequencer and scan state
    lmvs_pkg::state_t     state_reg, state_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic                 scan_active_reg, scan_active_next;
    logic signed [10:0]   active_level_reg, active_level_next;
    logic signed [31:0]   reclaim_reg, reclaim_next;
    logic [31:0]          deadline_reg, deadline_next;
    lmvs_pkg::res_kind_t  pending_reg, pending_next;

    // Configuration table
    logic [30:0]          thr_reg [lmvs_pkg::CFG_PAIRS];
    logic signed [10:0]   lvl_reg [lmvs_pkg::CFG_PAIRS];

    // Latched input item
    logic [1:0]           kind_reg;
    logic signed [31:0]   free_reg;
    logic signed [31:0]   file_reg;
    logic [30:0]          lru_reg;
    logic                 scan_req_reg;
    logic [21:0]          id_reg;
    logic signed [10:0]   score_reg;
    logic [30:0]          size_reg;
    logic                 kthread_reg;
    logic                 has_mem_reg;
    logic                 dying_reg;
    logic [31:0]          now_reg;

    // Result register
    logic                 out_valid_reg;
    lmvs_pkg::res_kind_t  out_kind_reg;
    logic signed [10:0]   out_level_reg;
    logic [21:0]          out_id_reg;
    logic signed [10:0]   out_score_reg;
    logic [30:0]          out_size_reg;
    logic signed [31:0]   out_recl_reg;
    logic                 out_last_reg;

    logic                 out_load;
    lmvs_pkg::res_kind_t  out_kind_d;
    logic [21:0]          out_id_d;
    logic signed [10:0]   out_score_d;
    logic [30:0]          out_size_d;
    logic signed [31:0]   out_recl_d;
    logic                 out_last_d;
    logic                 out_free;

    logic                         in_xfer;
    logic [lmvs_pkg::CFG_PAIR_W-1:0] pair_sel;
    logic                         last_pair;
    logic signed [10:0]           lvl_sel;
    logic                         full;

    lmvs_pkg::alu_req_t   alu_req;
    lmvs_pkg::alu_rsp_t   alu_rsp;
    lmvs_pkg::slot_cmd_t  slot_cmd;
    lmvs_pkg::slot_t      slot_rd;
    logic [CW-1:0]        slot_count;

    lmvs_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lmvs_slots u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (slot_cmd),
        .rd_idx  (lmvs_pkg::SLOT_W'(idx_reg)),
        .rd_data (slot_rd),
        .count   (slot_count)
    );

    assign item.ready = (state_reg == lmvs_pkg::ST_IDLE);
    assign in_xfer    = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign pair_sel   = lmvs_pkg::CFG_PAIR_W'(idx_reg);
    assign last_pair  = (idx_reg == SW'(lmvs_pkg::PAIRS_USED - 1));
    assign full       = (slot_count == CW'(lmvs_pkg::VICTIM_SLOTS));

    // Feed the shared unit for the current step
    always_comb
    begin
        alu_req    = '0;
        alu_req.op = lmvs_pkg::OP_ADD;
        case (state_reg)
            lmvs_pkg::ST_DECODE:
            begin
                alu_req.op = lmvs_pkg::OP_TIME;
                alu_req.a  = $signed({1'b0, now_reg});
                alu_req.c  = $signed({1'b0, deadline_reg});
            end
            lmvs_pkg::ST_LEVEL:
            begin
                alu_req.op = lmvs_pkg::OP_THR;
                alu_req.a  = 33'(free_reg);
                alu_req.b  = 33'(file_reg);
                alu_req.c  = $signed({2'b00, thr_reg[pair_sel]});
                alu_req.d  = $signed({2'b00, thr_reg[pair_sel]});
            end
            lmvs_pkg::ST_SEARCH:
            begin
                alu_req.op = lmvs_pkg::OP_KEY_GT;
                alu_req.a  = 33'(score_reg);
                alu_req.b  = $signed({2'b00, size_reg});
                alu_req.c  = 33'(slot_rd.score);
                alu_req.d  = $signed({2'b00, slot_rd.size});
            end
            lmvs_pkg::ST_EMIT:
            begin
                alu_req.op = lmvs_pkg::OP_SUB_SAT;
                alu_req.a  = 33'(reclaim_reg);
                alu_req.d  = $signed({2'b00, slot_rd.size});
            end
            lmvs_pkg::ST_DONE:
            begin
                alu_req.op = lmvs_pkg::OP_ADD;
                alu_req.a  = $signed({1'b0, now_reg});
                alu_req.c  = $signed(33'(lmvs_pkg::TICKS_PER_SECOND));
            end
            default:
            begin
                alu_req.op = lmvs_pkg::OP_ADD;
            end
        endcase
    end

    // Next state, scan updates and result loads
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        scan_active_next  = scan_active_reg;
        active_level_next = active_level_reg;
        reclaim_next      = reclaim_reg;
        deadline_next     = deadline_reg;
        pending_next      = pending_reg;
        slot_cmd          = '0;
        slot_cmd.pos      = CW'(idx_reg);
        slot_cmd.entry.id    = id_reg;
        slot_cmd.entry.score = score_reg;
        slot_cmd.entry.size  = size_reg;
        lvl_sel           = lmvs_pkg::LEVEL_NONE;
        out_load          = 1'b0;
        out_kind_d        = lmvs_pkg::RES_IDLE;
        out_id_d          = '0;
        out_score_d       = '0;
        out_size_d        = '0;
        out_recl_d        = '0;
        out_last_d        = 1'b0;

        case (state_reg)
            lmvs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = lmvs_pkg::ST_DECODE;
                end
            end

            lmvs_pkg::ST_DECODE:
            begin
                state_next = lmvs_pkg::ST_IDLE;
                case (kind_reg)
                    lmvs_pkg::KIND_BEGIN:
                    begin
                        idx_next   = '0;
                        state_next = lmvs_pkg::ST_LEVEL;
                    end
                    lmvs_pkg::KIND_TASK:
                    begin
                        if (scan_active_reg && !kthread_reg && has_mem_reg)
                        begin
                            if (dying_reg)
                            begin
                                // dying task at or before the deadline: abort
                                if (alu_rsp.flag)
                                begin
                                    scan_active_next = 1'b0;
                                    slot_cmd.clear   = 1'b1;
                                    pending_next     = lmvs_pkg::RES_ABORT;
                                    state_next       = lmvs_pkg::ST_RESULT;
                                end
                            end
                            else if (!(score_reg < active_level_reg) && (size_reg != '0))
                            begin
                                idx_next   = '0;
                                state_next = lmvs_pkg::ST_SEARCH;
                            end
                        end
                    end
                    lmvs_pkg::KIND_END:
                    begin
                        if (scan_active_reg)
                        begin
                            if (slot_count == '0)
                            begin
                                state_next = lmvs_pkg::ST_DONE;
                            end
                            else
                            begin
                                idx_next   = SW'(slot_count - CW'(1));
                                state_next = lmvs_pkg::ST_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = lmvs_pkg::ST_IDLE;
                    end
                endcase
            end

            lmvs_pkg::ST_LEVEL:
            begin
                if (alu_rsp.flag || last_pair)
                begin
                    lvl_sel = alu_rsp.flag ? lvl_reg[pair_sel] : lmvs_pkg::LEVEL_NONE;
                    active_level_next = lvl_sel;
                    reclaim_next      = $signed({1'b0, lru_reg});
                    slot_cmd.clear    = 1'b1;
                    if (!scan_req_reg || (lvl_sel == lmvs_pkg::LEVEL_NONE))
                    begin
                        scan_active_next = 1'b0;
                        pending_next     = lmvs_pkg::RES_IDLE;
                        state_next       = lmvs_pkg::ST_RESULT;
                    end
                    else
                    begin
                        scan_active_next = 1'b1;
                        state_next       = lmvs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            lmvs_pkg::ST_SEARCH:
            begin
                // advance past every kept entry the task exceeds
                if ((idx_reg < SW'(slot_count)) && alu_rsp.flag)
                begin
                    idx_next = idx_reg + SW'(1);
                end
                else
                begin
                    state_next = lmvs_pkg::ST_INSERT;
                end
            end

            lmvs_pkg::ST_INSERT:
            begin
                // drop a task no larger than everything in a full list
                if (!((idx_reg == '0) && full))
                begin
                    slot_cmd.insert = 1'b1;
                end
                state_next = lmvs_pkg::ST_IDLE;
            end

            lmvs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_kind_d   = lmvs_pkg::RES_VICTIM;
                    out_id_d     = slot_rd.id;
                    out_score_d  = slot_rd.score;
                    out_size_d   = slot_rd.size;
                    out_recl_d   = $signed(alu_rsp.value);
                    reclaim_next = $signed(alu_rsp.value);
                    if (idx_reg == '0)
                    begin
                        state_next = lmvs_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg - SW'(1);
                    end
                end
            end

            lmvs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind_d = lmvs_pkg::RES_DONE;
                    out_recl_d = reclaim_reg;
                    out_last_d = 1'b1;
                    // arm the deadline only when something was chosen
                    if (slot_count != '0)
                    begin
                        deadline_next = alu_rsp.value;
                    end
                    scan_active_next = 1'b0;
                    slot_cmd.clear   = 1'b1;
                    state_next       = lmvs_pkg::ST_IDLE;
                end
            end

            lmvs_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind_d = pending_reg;
                    out_recl_d = (pending_reg == lmvs_pkg::RES_IDLE) ? reclaim_reg : 32'sd0;
                    out_last_d = 1'b1;
                    state_next = lmvs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lmvs_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer and scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lmvs_pkg::ST_IDLE;
            idx_reg          <= '0;
            scan_active_reg  <= 1'b0;
            active_level_reg <= lmvs_pkg::LEVEL_NONE;
            reclaim_reg      <= '0;
            deadline_reg     <= '0;
            pending_reg      <= lmvs_pkg::RES_IDLE;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            scan_active_reg  <= scan_active_next;
            active_level_reg <= active_level_next;
            reclaim_reg      <= reclaim_next;
            deadline_reg     <= deadline_next;
            pending_reg      <= pending_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0] <= lmvs_pkg::THR_RESET_0;
            thr_reg[1] <= lmvs_pkg::THR_RESET_1;
            thr_reg[2] <= lmvs_pkg::THR_RESET_2;
            thr_reg[3] <= lmvs_pkg::THR_RESET_3;
            lvl_reg[0] <= lmvs_pkg::LVL_RESET_0;
            lvl_reg[1] <= lmvs_pkg::LVL_RESET_1;
            lvl_reg[2] <= lmvs_pkg::LVL_RESET_2;
            lvl_reg[3] <= lmvs_pkg::LVL_RESET_3;
        end
        else if (cfg_we)
        begin
            if ((cfg_index >= lmvs_pkg::CFG_FREE_THRESHOLD_0) &&
                (cfg_index < lmvs_pkg::CFG_SCORE_LEVEL_0))
            begin
                thr_reg[cfg_index[lmvs_pkg::CFG_PAIR_W-1:0]] <= cfg_data;
            end
            else
            begin
                lvl_reg[cfg_index[lmvs_pkg::CFG_PAIR_W-1:0]] <= $signed(cfg_data[10:0]);
            end
        end
    end

    // Latch the input item on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg     <= item.kind;
            free_reg     <= item.free_pages;
            file_reg     <= item.file_pages;
            lru_reg      <= item.lru_pages;
            scan_req_reg <= item.scan_requested;
            id_reg       <= item.task_id;
            score_reg    <= item.task_score;
            size_reg     <= item.task_size;
            kthread_reg  <= item.is_kernel_thread;
            has_mem_reg  <= item.has_memory;
            dying_reg    <= item.is_dying;
            now_reg      <= item.now_ticks;
        end
    end

    // Result register: hold until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= out_kind_d;
            out_level_reg <= active_level_next;
            out_id_reg    <= out_id_d;
            out_score_reg <= out_score_d;
            out_size_reg  <= out_size_d;
            out_recl_reg  <= out_recl_d;
            out_last_reg  <= out_last_d;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.chosen_level = out_level_reg;
    assign result.victim_id    = out_id_reg;
    assign result.victim_score = out_score_reg;
    assign result.victim_size  = out_size_reg;
    assign result.reclaimable  = out_recl_reg;
    assign result.last         = out_last_reg;

    // Fill count never passes the slot total
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_count <= CW'(lmvs_pkg::VICTIM_SLOTS))
        else $error("slot count beyond the slot total");

    // Victims are only handed out of an open scan
    a_victim_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_kind_d == lmvs_pkg::RES_VICTIM)) |-> scan_active_reg)
        else $error("victim emitted without an open scan");

    // One item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input ready straight after a transfer");

    // A result is loaded only when the result register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten");
endmodule

`default_nettype wire
